/* src/qebp_pkg.sv */
// shared types and constants for the quadrature encoder button pulser
package qebp_pkg;

    localparam int unsigned MASK_W     = 15;
    localparam int unsigned MASK_BYTES = (MASK_W + 7) / 8;
    localparam int unsigned OUT_W      = MASK_BYTES * 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PULSE_W    = 10;
    localparam int unsigned DEBOUNCE_W = 8;
    localparam int unsigned CFG_W      = PULSE_W;

    localparam logic [PULSE_W-1:0]    PULSE_TIME_RESET    = 10'd20;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TIME_RESET = 8'd8;

    typedef enum logic [0:0] {
        CFG_PULSE_TIME    = 1'b0,
        CFG_DEBOUNCE_TIME = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } step_t;

    // indexed by {previous A/B, current A/B}
    localparam step_t QUAD_STEP [16] = '{
        STEP_NONE, STEP_CCW,  STEP_CW,   STEP_NONE,
        STEP_CW,   STEP_NONE, STEP_NONE, STEP_CCW,
        STEP_CCW,  STEP_NONE, STEP_NONE, STEP_CW,
        STEP_NONE, STEP_CW,   STEP_CCW,  STEP_NONE
    };

    typedef struct packed {
        logic cw;
        logic ccw;
        logic sw;
    } lane_status_t;

endpackage

/* src/qebp_lane.sv */
// one encoder lane: quadrature step decode, pulse timers and switch debounce
module qebp_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              primed,
    input  logic [1:0]                        ab,
    input  logic                              raw,
    input  logic [qebp_pkg::TIME_W-1:0]       now,
    input  logic [qebp_pkg::PULSE_W-1:0]      pulse_time,
    input  logic [qebp_pkg::DEBOUNCE_W-1:0]   debounce_time,
    output qebp_pkg::lane_status_t            status_next
);

    logic [1:0]                  prev_ab_reg, prev_ab_next;
    logic                        raw_prev_reg, raw_prev_next;
    logic                        stable_reg, stable_next;
    logic [qebp_pkg::TIME_W-1:0] change_time_reg, change_time_next;
    logic                        cw_active_reg, cw_active_next;
    logic                        ccw_active_reg, ccw_active_next;
    logic [qebp_pkg::TIME_W-1:0] cw_deadline_reg, cw_deadline_next;
    logic [qebp_pkg::TIME_W-1:0] ccw_deadline_reg, ccw_deadline_next;

    qebp_pkg::step_t             step;
    logic [qebp_pkg::TIME_W-1:0] elapsed;
    logic [qebp_pkg::TIME_W-1:0] cw_late;
    logic [qebp_pkg::TIME_W-1:0] ccw_late;
    logic [qebp_pkg::TIME_W-1:0] new_deadline;
    logic                        pulse_nonzero;

    always_comb begin
        step          = qebp_pkg::QUAD_STEP[{prev_ab_reg, ab}];
        elapsed       = now - change_time_reg;
        cw_late       = now - cw_deadline_reg;
        ccw_late      = now - ccw_deadline_reg;
        new_deadline  = now + qebp_pkg::TIME_W'(pulse_time);
        pulse_nonzero = (pulse_time != '0);

        prev_ab_next      = ab;
        raw_prev_next     = raw_prev_reg;
        stable_next       = stable_reg;
        change_time_next  = change_time_reg;
        cw_active_next    = cw_active_reg;
        ccw_active_next   = ccw_active_reg;
        cw_deadline_next  = cw_deadline_reg;
        ccw_deadline_next = ccw_deadline_reg;

        if (!primed) begin
            raw_prev_next    = raw;
            stable_next      = raw;
            change_time_next = now;
        end else begin
            // a fresh pulse only expires at once when the pulse time is zero
            if (step == qebp_pkg::STEP_CW) begin
                cw_active_next   = pulse_nonzero;
                cw_deadline_next = new_deadline;
            end else begin
                cw_active_next = cw_active_reg && cw_late[qebp_pkg::TIME_W-1];
            end
            if (step == qebp_pkg::STEP_CCW) begin
                ccw_active_next   = pulse_nonzero;
                ccw_deadline_next = new_deadline;
            end else begin
                ccw_active_next = ccw_active_reg && ccw_late[qebp_pkg::TIME_W-1];
            end

            if (raw != raw_prev_reg) begin
                raw_prev_next    = raw;
                change_time_next = now;
            end else if (elapsed >= qebp_pkg::TIME_W'(debounce_time)) begin
                stable_next = raw;
            end
        end

        status_next.cw  = cw_active_next;
        status_next.ccw = ccw_active_next;
        status_next.sw  = stable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_active_reg  <= 1'b0;
            ccw_active_reg <= 1'b0;
            stable_reg     <= 1'b0;
        end else if (accept) begin
            cw_active_reg  <= cw_active_next;
            ccw_active_reg <= ccw_active_next;
            stable_reg     <= stable_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_ab_reg      <= prev_ab_next;
            raw_prev_reg     <= raw_prev_next;
            change_time_reg  <= change_time_next;
            cw_deadline_reg  <= cw_deadline_next;
            ccw_deadline_reg <= ccw_deadline_next;
        end
    end

endmodule

/* src/qebp_merge.sv */
// merges lane status into the button mask and holds results in an output skid buffer
module qebp_merge #(
    parameter int unsigned ENCODER_COUNT = 5
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_fire,
    input  qebp_pkg::lane_status_t           lane_status [ENCODER_COUNT],
    output logic                             in_ready,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [qebp_pkg::OUT_W-1:0]       m_axis_tdata
);

    logic [qebp_pkg::MASK_W-1:0] mask;
    logic                        main_valid_reg, skid_valid_reg;
    logic [qebp_pkg::MASK_W-1:0] main_data_reg, skid_data_reg;
    logic                        pop;

    for (genvar b = 0; b < qebp_pkg::MASK_W; b++) begin : g_bit
        if (b / 3 < ENCODER_COUNT) begin : g_used
            if (b % 3 == 0) begin : g_cw
                assign mask[b] = lane_status[b / 3].cw;
            end else if (b % 3 == 1) begin : g_ccw
                assign mask[b] = lane_status[b / 3].ccw;
            end else begin : g_sw
                assign mask[b] = lane_status[b / 3].sw;
            end
        end else begin : g_unused
            assign mask[b] = 1'b0;
        end
    end

    assign pop           = main_valid_reg && m_axis_tready;
    assign in_ready      = !skid_valid_reg;
    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tdata  = qebp_pkg::OUT_W'(main_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop || !main_valid_reg) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : mask;
        end else if (in_fire) begin
            skid_data_reg <= mask;
        end
    end

endmodule

/* src/quadrature_encoder_button_pulser.sv */
// top level of the quadrature encoder button pulser
// Each transaction carries one sample of all encoder A/B pins, the push switches
// and a millisecond timestamp, and yields one 15-bit button mask. The block
// takes one transaction every clock while its output buffer has room and
// registers each mask there; one lane per encoder decodes the step, runs the
// CW/CCW pulse timers and debounces the switch in shallow combinational table
// lookup and 32-bit compares. A two-entry output buffer keeps input accepted
// for one more transaction while the result side is stalled. The first transaction after
// reset only primes the pin and switch history and shows the sampled switches.
module quadrature_encoder_button_pulser #(
    parameter int unsigned ENCODER_COUNT = 5
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // ab_pins, switch_pressed, now_ms
    input  logic [((3*ENCODER_COUNT+qebp_pkg::TIME_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // button_mask
    output logic [qebp_pkg::OUT_W-1:0]                    m_axis_tdata,
    input  logic                                          cfg_wen,
    input  logic [0:0]                                    cfg_addr,
    input  logic [qebp_pkg::CFG_W-1:0]                    cfg_wdata
);

    localparam int unsigned AB_W  = 2 * ENCODER_COUNT;
    localparam int unsigned SW_LO = AB_W;
    localparam int unsigned NOW_LO = AB_W + ENCODER_COUNT;

    logic                                in_fire;
    logic                                in_ready;
    logic                                primed_reg;
    logic [qebp_pkg::PULSE_W-1:0]        pulse_time_reg;
    logic [qebp_pkg::DEBOUNCE_W-1:0]     debounce_time_reg;
    logic [AB_W-1:0]                     ab_pins;
    logic [ENCODER_COUNT-1:0]            switch_pressed;
    logic [qebp_pkg::TIME_W-1:0]         now_ms;
    qebp_pkg::lane_status_t              lane_status [ENCODER_COUNT];

    assign ab_pins        = s_axis_tdata[AB_W-1:0];
    assign switch_pressed = s_axis_tdata[SW_LO +: ENCODER_COUNT];
    assign now_ms         = s_axis_tdata[NOW_LO +: qebp_pkg::TIME_W];

    assign s_axis_tready = in_ready;
    assign in_fire       = s_axis_tvalid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_time_reg    <= qebp_pkg::PULSE_TIME_RESET;
            debounce_time_reg <= qebp_pkg::DEBOUNCE_TIME_RESET;
        end else if (cfg_wen) begin
            if (cfg_addr == qebp_pkg::CFG_PULSE_TIME) begin
                pulse_time_reg <= cfg_wdata;
            end else begin
                debounce_time_reg <= cfg_wdata[qebp_pkg::DEBOUNCE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (in_fire) begin
            primed_reg <= 1'b1;
        end
    end

    for (genvar i = 0; i < ENCODER_COUNT; i++) begin : g_lane
        qebp_lane u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .accept        (in_fire),
            .primed        (primed_reg),
            .ab            (ab_pins[2*i +: 2]),
            .raw           (switch_pressed[i]),
            .now           (now_ms),
            .pulse_time    (pulse_time_reg),
            .debounce_time (debounce_time_reg),
            .status_next   (lane_status[i])
        );
    end

    qebp_merge #(
        .ENCODER_COUNT (ENCODER_COUNT)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (in_fire),
        .lane_status   (lane_status),
        .in_ready      (in_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* src/qebp_checker.sv */
// port-level checker for the quadrature encoder button pulser, bound to the top level
module qebp_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [qebp_pkg::OUT_W-1:0] m_axis_tdata
);

    a_valid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_result_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("accepted transaction gave no result");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[qebp_pkg::OUT_W-1:qebp_pkg::MASK_W] == '0)
        else $error("mask padding not zero");

endmodule

bind quadrature_encoder_button_pulser qebp_checker u_qebp_checker (.*);

/* bench/qebp_mask_checker.sv */
// checker that predicts and compares the button mask of every transaction
`timescale 1ns / 100ps

module qebp_mask_checker
    import qebp_pkg::*;
#(
    parameter int unsigned LANES = 5,
    parameter int unsigned IN_W  = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_wen,
    input  logic [0:0]       cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               mismatches,
    output int               outstanding
);

    // step decoded from {old A/B, new A/B}
    localparam step_t PHASE_STEP [16] = '{
        STEP_NONE, STEP_CCW,  STEP_CW,   STEP_NONE,
        STEP_CW,   STEP_NONE, STEP_NONE, STEP_CCW,
        STEP_CCW,  STEP_NONE, STEP_NONE, STEP_CW,
        STEP_NONE, STEP_CW,   STEP_CCW,  STEP_NONE
    };

    logic [PULSE_W-1:0]    pulse_ms;
    logic [DEBOUNCE_W-1:0] debounce_ms;
    logic                  primed;
    logic [1:0]            last_ab    [LANES];
    logic                  raw_last   [LANES];
    logic                  sw_level   [LANES];
    logic [TIME_W-1:0]     raw_since  [LANES];
    logic                  held       [2*LANES];
    logic [TIME_W-1:0]     release_at [2*LANES];
    logic [MASK_W-1:0]     expected_masks [$];

    function automatic logic [MASK_W-1:0] button_mask_after(input logic [2*LANES-1:0] pins,
                                                           input logic [LANES-1:0] sw,
                                                           input logic [TIME_W-1:0] now);
        logic [MASK_W-1:0] m;
        logic [1:0]        cur;
        step_t             s;
        logic [TIME_W-1:0] elapsed;
        m = '0;
        for (int i = 0; i < LANES; i++) begin
            cur = pins[2*i +: 2];
            if (!primed) begin
                last_ab[i]   = cur;
                raw_last[i]  = sw[i];
                sw_level[i]  = sw[i];
                raw_since[i] = now;
            end else begin
                s = PHASE_STEP[{last_ab[i], cur}];
                if (s == STEP_CW) begin
                    held[2*i]       = 1'b1;
                    release_at[2*i] = now + TIME_W'(pulse_ms);
                end else if (s == STEP_CCW) begin
                    held[2*i+1]       = 1'b1;
                    release_at[2*i+1] = now + TIME_W'(pulse_ms);
                end
                last_ab[i] = cur;
                elapsed = now - raw_since[i];
                if (sw[i] != raw_last[i]) begin
                    raw_last[i]  = sw[i];
                    raw_since[i] = now;
                end else if (elapsed >= TIME_W'(debounce_ms)) begin
                    sw_level[i] = sw[i];
                end
            end
        end
        if (primed) begin
            // wrap-safe deadline: released once now is not behind the deadline
            for (int p = 0; p < 2*LANES; p++) begin
                elapsed = now - release_at[p];
                if (held[p] && !elapsed[TIME_W-1]) begin
                    held[p]       = 1'b0;
                    release_at[p] = '0;
                end
            end
        end
        primed = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            m[3*i]   = held[2*i];
            m[3*i+1] = held[2*i+1];
            m[3*i+2] = sw_level[i];
        end
        return m;
    endfunction

    always @(posedge aclk) begin
        logic [MASK_W-1:0] want;
        if (!aresetn) begin
            pulse_ms    = PULSE_TIME_RESET;
            debounce_ms = DEBOUNCE_TIME_RESET;
            primed      = 1'b0;
            for (int i = 0; i < LANES; i++) begin
                last_ab[i]   = '0;
                raw_last[i]  = 1'b0;
                sw_level[i]  = 1'b0;
                raw_since[i] = '0;
            end
            for (int p = 0; p < 2*LANES; p++) begin
                held[p]       = 1'b0;
                release_at[p] = '0;
            end
            expected_masks.delete();
            mismatches = 0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_PULSE_TIME:    pulse_ms    = cfg_wdata[PULSE_W-1:0];
                    CFG_DEBOUNCE_TIME: debounce_ms = cfg_wdata[DEBOUNCE_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_masks.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected mask transaction 0x%04h", $realtime,
                                 m_axis_tdata);
                end else begin
                    want = expected_masks.pop_front();
                    if (m_axis_tdata !== OUT_W'(want)) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: button_mask expected 0x%04h got 0x%04h",
                                     $realtime, want, m_axis_tdata);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_masks.push_back(button_mask_after(
                    s_axis_tdata[2*LANES-1:0],
                    s_axis_tdata[3*LANES-1:2*LANES],
                    s_axis_tdata[3*LANES +: TIME_W]));
        end
        outstanding <= expected_masks.size();
    end

endmodule

/* bench/tb_quadrature_encoder_button_pulser.sv */
// top of the button pulser bench: clock, reset, stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_quadrature_encoder_button_pulser;
    import qebp_pkg::*;

    localparam int unsigned LANES = 5;
    localparam int unsigned IN_W  = ((3*LANES + TIME_W + 7) / 8) * 8;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_wen       = 1'b0;
    logic [0:0]       cfg_addr      = '0;
    logic [CFG_W-1:0] cfg_wdata     = '0;

    int mismatches;
    int outstanding;

    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    logic rx_hold_req = 1'b0;

    logic [2*LANES-1:0] pins_now = '0;
    logic [LANES-1:0]   sw_now   = '0;
    logic [TIME_W-1:0]  ms_now   = '0;

    always #6 aclk = ~aclk;

    quadrature_encoder_button_pulser #(.ENCODER_COUNT(LANES)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    qebp_mask_checker #(.LANES(LANES), .IN_W(IN_W)) mask_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // receiver: random stalls, quiet stretches and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            m_axis_tready <= rx_calm || ($urandom_range(99) >= 10);
        end
    end

    initial begin
        #3_000_000;
        $display("quadrature_encoder_button_pulser test failed");
        $finish;
    end

    task automatic send_sample(input logic [2*LANES-1:0] pins, input logic [LANES-1:0] sw,
                               input logic [TIME_W-1:0] now);
        while (!tx_calm && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({now, sw, pins});
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] debounce);
        cfg_wen   <= 1'b1;
        cfg_addr  <= CFG_PULSE_TIME;
        cfg_wdata <= pulse;
        @(posedge aclk);
        cfg_addr  <= CFG_DEBOUNCE_TIME;
        cfg_wdata <= debounce;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        @(posedge aclk);
    endtask

    // encoders mostly hold or step cleanly, with a few skipped or random states
    task automatic send_random_sample();
        logic [1:0] ab;
        int         r;
        for (int i = 0; i < LANES; i++) begin
            ab = pins_now[2*i +: 2];
            r = $urandom_range(99);
            if (r < 14)
                ab = {~ab[0], ab[1]};
            else if (r < 28)
                ab = {ab[0], ~ab[1]};
            else if (r < 31)
                ab = ~ab;
            else if (r < 33)
                ab = 2'($urandom);
            pins_now[2*i +: 2] = ab;
            if ($urandom_range(99) < 6)
                sw_now[i] = ~sw_now[i];
        end
        r = $urandom_range(99);
        if (r < 55)
            ms_now = ms_now + $urandom_range(3);
        else if (r < 85)
            ms_now = ms_now + $urandom_range(40);
        else if (r < 97)
            ms_now = ms_now + $urandom_range(1200);
        else
            ms_now = $urandom;
        send_sample(pins_now, sw_now, ms_now);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // priming, then clean steps, skipped steps, debounce and time wrap
        send_sample(10'h3FF, 5'h1F, 32'hFFFF_FFF0);
        send_sample(10'h3FF, 5'h1F, 32'hFFFF_FFF1);
        send_sample(10'h155, 5'h1F, 32'hFFFF_FFF4);
        send_sample(10'h3FF, 5'h1F, 32'hFFFF_FFF8);
        send_sample(10'h000, 5'h1F, 32'hFFFF_FFFC);
        send_sample(10'h000, 5'h00, 32'h0000_0002);
        send_sample(10'h000, 5'h00, 32'h0000_0009);
        send_sample(10'h000, 5'h00, 32'h0000_000A);
        send_sample(10'h000, 5'h15, 32'h0000_000B);
        send_sample(10'h000, 5'h00, 32'h0000_000C);
        send_sample(10'h000, 5'h0A, 32'h0000_0020);
        send_sample(10'h000, 5'h0A, 32'h0000_0028);
        send_sample(10'h2C6, 5'h0A, 32'hFFFF_FFFF);
        send_sample(10'h2C7, 5'h0A, 32'h0000_0005);
        send_sample(10'h2C7, 5'h0A, 32'h0000_0013);
        send_sample(10'h2C7, 5'h0A, 32'h0000_0019);
        send_sample(10'h2C7, 5'h0A, 32'h7FFF_FFFF);
        send_sample(10'h2C7, 5'h0A, 32'h8000_0000);
        pins_now = 10'h2C7;
        sw_now   = 5'h0A;
        ms_now   = 32'h8000_0000;

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: set_config(10'd1, 10'd0);
                1: set_config(10'd1000, 10'd255);
                2: set_config(10'd0, 10'h3C5);
                3: set_config(10'h3FF, CFG_W'($urandom_range(1023)));
                default: set_config(CFG_W'($urandom_range(1000, 1)),
                                    CFG_W'($urandom_range(255)));
            endcase
            ms_now = (ph == 2) ? 32'hFFFF_F000 : 32'($urandom);
            for (int n = 0; n < 250; n++) begin
                tx_calm = (n >= 150 && n < 200);
                rx_calm = tx_calm;
                if (ph == 1 && n == 100)
                    rx_hold_req = 1'b1;
                if (ph == 3 && n == 120)
                    drain();
                send_random_sample();
            end
            tx_calm = 1'b0;
            rx_calm = 1'b0;
        end

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("quadrature_encoder_button_pulser test passed");
        else
            $display("quadrature_encoder_button_pulser test failed");
        $finish;
    end

endmodule
